// ===== src/tcpa_pkg.sv =====
// Shared types, constants and helpers for the two-class pool allocator.
// No dependencies; imported by the controller, the datapath and the top level.
package tcpa_pkg;

	localparam int IN_W  = 32;
	localparam int OUT_W = 24;
	localparam int CFG_W = 11;
	localparam int ROW_BITS = 32;

	localparam logic        CMD_ALLOC  = 1'b0;
	localparam logic        CMD_FREE   = 1'b1;
	localparam logic [10:0] SMALL_SIZE = 11'd32;
	localparam logic [10:0] LARGE_SIZE = 11'd1024;
	localparam logic [15:0] LARGE_BASE = 16'h8000;

	typedef enum logic {
		REG_SMALL_COUNT = 1'b0,
		REG_LARGE_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NO_BLOCK = 2'd1,
		ST_BAD_SIZE = 2'd2
	} status_t;

	typedef struct packed {
		logic accept;
		logic commit;
	} ctrl_cmd_t;

	// {found, index} of the lowest clear bit
	function automatic logic [5:0] lowest_zero(input logic [31:0] v);
		logic [5:0] r;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			if (!v[i]) r = {1'b1, 5'(i)};
		end
		return r;
	endfunction

endpackage

// ===== src/tcpa_ctrl.sv =====
// Controller for the pool allocator: accept / commit sequencing and output valid.
// Depends on tcpa_pkg.
module tcpa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output tcpa_pkg::ctrl_cmd_t cmd
);
	import tcpa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_COMMIT = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_vld_q;

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.accept = in_valid && in_ready;
	assign cmd.commit = (state_q == S_COMMIT) && (!out_vld_q || out_ready);
	assign out_valid  = out_vld_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.accept) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (cmd.commit) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/tcpa_dp.sv =====
// Datapath for the pool allocator: bitmaps, counters, search and result register.
// Depends on tcpa_pkg; driven by tcpa_ctrl commands.
module tcpa_dp #(
	parameter int SMALL_BLOCKS = 1024,
	parameter int LARGE_BLOCKS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcpa_pkg::ctrl_cmd_t         cmd,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [tcpa_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic [tcpa_pkg::IN_W-1:0]   in_data,
	output logic [tcpa_pkg::OUT_W-1:0]  out_data
);
	import tcpa_pkg::*;

	localparam int SMALL_ROWS = (SMALL_BLOCKS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_W  = (SMALL_ROWS > 1) ? $clog2(SMALL_ROWS) : 1;
	localparam int LIDX_W = (LARGE_BLOCKS > 1) ? $clog2(LARGE_BLOCKS) : 1;
	localparam logic [10:0] SMALL_LIM = 11'(SMALL_BLOCKS);
	localparam logic [5:0]  LARGE_LIM = 6'(LARGE_BLOCKS);

	typedef enum logic [2:0] {
		OP_ALLOC_SMALL = 3'd0,
		OP_ALLOC_LARGE = 3'd1,
		OP_NO_BLOCK    = 3'd2,
		OP_BAD_SIZE    = 3'd3,
		OP_FREE_SMALL  = 3'd4,
		OP_FREE_LARGE  = 3'd5,
		OP_FREE_NONE   = 3'd6
	} op_t;

	logic                     cmd_in;
	logic [10:0]              size_in;
	logic [15:0]              addr_in;

	logic [10:0]              small_cnt_q;
	logic [5:0]               large_cnt_q;
	logic [10:0]              small_left_q;
	logic [5:0]               large_left_q;
	logic [SMALL_ROWS-1:0]    row_vld_q;
	logic [SMALL_ROWS-1:0]    row_full_q;
	logic [LARGE_BLOCKS-1:0]  large_map_q;
	logic [ROW_BITS-1:0]      small_map_mem [SMALL_ROWS];
	logic [ROW_BITS-1:0]      rd_word_q;

	op_t                      op_q, op_d;
	logic [ROW_W-1:0]         row_q, rd_row;
	logic [4:0]               bit_q;
	logic [LIDX_W-1:0]        lidx_q;
	status_t                  status_q, status_d;
	logic [15:0]              granted_q, granted_d;

	logic [31:0]              full32, lmap32, word, pad, word_new;
	logic [5:0]               row_pick, bit_pick, lg_pick;
	logic [9:0]               fidx;
	logic [4:0]               lidx5;
	logic                     fidx_ok, lidx_ok;
	logic [10:0]              small_total, large_total_w, new_small, new_small_sat;
	logic [5:0]               large_total, new_large, new_large_sat;
	logic                     mem_we, small_dec, small_inc, large_dec, large_inc;
	logic                     row_upd, row_full_d, lg_set, lg_clr;

	assign cmd_in  = in_data[0];
	assign size_in = in_data[11:1];
	assign addr_in = in_data[27:12];

	assign small_total   = (small_cnt_q > SMALL_LIM) ? SMALL_LIM : small_cnt_q;
	assign large_total   = (large_cnt_q > LARGE_LIM) ? LARGE_LIM : large_cnt_q;
	assign large_total_w = 11'(large_total);
	assign new_small     = (cfg_index == REG_SMALL_COUNT) ? cfg_wdata : small_cnt_q;
	assign new_large     = (cfg_index == REG_LARGE_COUNT) ? cfg_wdata[5:0] : large_cnt_q;
	assign new_small_sat = (new_small > SMALL_LIM) ? SMALL_LIM : new_small;
	assign new_large_sat = (new_large > LARGE_LIM) ? LARGE_LIM : new_large;

	// classify the incoming item
	always_comb begin
		full32 = '1;
		full32[SMALL_ROWS-1:0] = row_full_q;
		row_pick = lowest_zero(full32);
		fidx     = addr_in[14:5];
		fidx_ok  = ({1'b0, fidx} < SMALL_LIM);
		lidx5    = addr_in[14:10];
		lidx_ok  = ({1'b0, lidx5} < LARGE_LIM);
		priority if (cmd_in == CMD_FREE) begin
			if (!addr_in[15]) op_d = fidx_ok ? OP_FREE_SMALL : OP_FREE_NONE;
			else              op_d = lidx_ok ? OP_FREE_LARGE : OP_FREE_NONE;
		end else if (size_in == SMALL_SIZE) begin
			if (small_left_q != '0)      op_d = row_pick[5] ? OP_ALLOC_SMALL : OP_NO_BLOCK;
			else if (large_left_q != '0) op_d = OP_ALLOC_LARGE;
			else                         op_d = OP_NO_BLOCK;
		end else if (size_in == LARGE_SIZE) begin
			op_d = (large_left_q != '0) ? OP_ALLOC_LARGE : OP_NO_BLOCK;
		end else begin
			op_d = OP_BAD_SIZE;
		end
		rd_row = (cmd_in == CMD_FREE) ? ROW_W'(fidx[9:5]) : ROW_W'(row_pick[4:0]);
	end

	// finish the item held from the accept cycle
	always_comb begin
		word = row_vld_q[row_q] ? rd_word_q : '0;
		for (int b = 0; b < 32; b++) begin
			pad[b] = (((11'(row_q) << 5) | 11'(b)) >= SMALL_LIM);
		end
		bit_pick = lowest_zero(word | pad);
		lmap32 = '1;
		lmap32[LARGE_BLOCKS-1:0] = large_map_q;
		lg_pick = lowest_zero(lmap32);

		word_new   = word;
		mem_we     = 1'b0;
		row_upd    = 1'b0;
		row_full_d = 1'b0;
		small_dec  = 1'b0;
		small_inc  = 1'b0;
		large_dec  = 1'b0;
		large_inc  = 1'b0;
		lg_set     = 1'b0;
		lg_clr     = 1'b0;
		status_d   = ST_DONE;
		granted_d  = '0;
		unique case (op_q)
			OP_ALLOC_SMALL: begin
				if (bit_pick[5]) begin
					word_new   = word | (32'd1 << bit_pick[4:0]);
					mem_we     = 1'b1;
					row_upd    = 1'b1;
					row_full_d = &(word_new | pad);
					small_dec  = 1'b1;
					granted_d  = (16'(row_q) << 10) | (16'(bit_pick[4:0]) << 5);
				end else begin
					status_d = ST_NO_BLOCK;
				end
			end
			OP_ALLOC_LARGE: begin
				if (lg_pick[5]) begin
					lg_set    = 1'b1;
					large_dec = 1'b1;
					granted_d = LARGE_BASE | (16'(lg_pick[4:0]) << 10);
				end else begin
					status_d = ST_NO_BLOCK;
				end
			end
			OP_FREE_SMALL: begin
				word_new  = word & ~(32'd1 << bit_q);
				mem_we    = 1'b1;
				row_upd   = 1'b1;
				small_inc = (small_left_q < small_total);
			end
			OP_FREE_LARGE: begin
				lg_clr    = 1'b1;
				large_inc = ({5'b0, large_left_q} < large_total_w);
			end
			OP_NO_BLOCK:  status_d = ST_NO_BLOCK;
			OP_BAD_SIZE:  status_d = ST_BAD_SIZE;
			OP_FREE_NONE: status_d = ST_DONE;
			default:      status_d = ST_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_cnt_q  <= '0;
			large_cnt_q  <= '0;
			small_left_q <= '0;
			large_left_q <= '0;
			row_vld_q    <= '0;
			row_full_q   <= '0;
			large_map_q  <= '0;
		end else if (cfg_we) begin
			small_cnt_q  <= new_small;
			large_cnt_q  <= new_large;
			small_left_q <= new_small_sat;
			large_left_q <= new_large_sat;
			row_vld_q    <= '0;
			row_full_q   <= '0;
			large_map_q  <= '0;
		end else if (cmd.commit) begin
			if (row_upd) begin
				row_vld_q[row_q]  <= 1'b1;
				row_full_q[row_q] <= row_full_d;
			end
			if (small_dec) small_left_q <= small_left_q - 11'd1;
			if (small_inc) small_left_q <= small_left_q + 11'd1;
			if (large_dec) large_left_q <= large_left_q - 6'd1;
			if (large_inc) large_left_q <= large_left_q + 6'd1;
			if (lg_set) large_map_q[LIDX_W'(lg_pick[4:0])] <= 1'b1;
			if (lg_clr) large_map_q[lidx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= op_d;
			row_q     <= rd_row;
			bit_q     <= fidx[4:0];
			lidx_q    <= LIDX_W'(lidx5);
			rd_word_q <= small_map_mem[rd_row];
		end
		if (cmd.commit && mem_we) small_map_mem[row_q] <= word_new;
		if (cmd.commit) begin
			status_q  <= status_d;
			granted_q <= granted_d;
		end
	end

	assign out_data = {6'b0, granted_q, status_q};

endmodule

// ===== src/two_class_pool_allocator.sv =====
// Two-class pool allocator: 32-byte blocks below 32768, 1024-byte blocks above.
// An accepted item is registered with its small-bitmap row and finished into the result
// register at commit; a result still held on the output delays the commit. A new item is
// taken only after the last commits, set by the registered row read and its read-modify-write.
// Reset clears registers, counters and all in-use flags at once through per-row
// valid bits; there is no clearing pass.
module two_class_pool_allocator #(
	parameter int SMALL_BLOCKS = 1024,
	parameter int LARGE_BLOCKS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [tcpa_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// [0] command, [11:1] request_size, [27:12] block_address, [31:28] zero
	input  logic [tcpa_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [1:0] status, [17:2] granted_address, [23:18] zero
	output logic [tcpa_pkg::OUT_W-1:0]  m_axis_tdata
);
	import tcpa_pkg::*;

	ctrl_cmd_t cmd;

	tcpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	tcpa_dp #(
		.SMALL_BLOCKS (SMALL_BLOCKS),
		.LARGE_BLOCKS (LARGE_BLOCKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata),
		.out_data  (m_axis_tdata)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !s_axis_tready)
		else $error("input ready while an item is in flight");

	a_result_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_axis_tvalid)
		else $error("committed result not presented");

	a_no_commit_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !s_axis_tready)
		else $error("commit without an accepted item");

	a_zero_addr_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[1:0] != ST_DONE)) |-> (m_axis_tdata[17:2] == 16'd0))
		else $error("nonzero address with failing status");

endmodule

// ===== dv/two_class_pool_allocator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for two_class_pool_allocator, built on tcpa_pkg.
// Directed and random allocate/free traffic on the streams, checked against an
// internal model of both bitmaps and counters.
module two_class_pool_allocator_tb;
	import tcpa_pkg::*;

	localparam int SMALL_BLOCKS = 1024;
	localparam int LARGE_BLOCKS = 32;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		status_t     status;
		logic [15:0] addr;
	} pool_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	// [0] command, [11:1] request_size, [27:12] block_address, [31:28] zero
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	// [1:0] status, [17:2] granted_address, [23:18] zero
	logic [OUT_W-1:0]  m_axis_tdata;

	logic [SMALL_BLOCKS-1:0] small_map;
	logic [LARGE_BLOCKS-1:0] large_map;
	logic [10:0]             small_count_reg;
	logic [5:0]              large_count_reg;
	int unsigned             small_left;
	int unsigned             large_left;

	pool_result_t expected_results[$];
	int           mismatches = 0;
	int           cycles = 0;
	int           hold_request = 0;
	int           hold_left = 0;
	bit           steady = 1'b0;

	two_class_pool_allocator #(
		.SMALL_BLOCKS(SMALL_BLOCKS),
		.LARGE_BLOCKS(LARGE_BLOCKS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #6 clk = ~clk;

	function automatic int unsigned small_total();
		return (small_count_reg > SMALL_BLOCKS) ? SMALL_BLOCKS : small_count_reg;
	endfunction

	function automatic int unsigned large_total();
		return (large_count_reg > LARGE_BLOCKS) ? LARGE_BLOCKS : large_count_reg;
	endfunction

	function automatic void reload_pools();
		small_map = '0;
		large_map = '0;
		small_left = small_total();
		large_left = large_total();
	endfunction

	function automatic pool_result_t grant_large();
		pool_result_t r;
		r.status = ST_NO_BLOCK;
		r.addr = '0;
		for (int i = 0; i < LARGE_BLOCKS; i++) begin
			if (!large_map[i]) begin
				large_map[i] = 1'b1;
				large_left--;
				r.status = ST_DONE;
				r.addr = LARGE_BASE + 16'(i * 1024);
				return r;
			end
		end
		return r;
	endfunction

	function automatic pool_result_t predict_result(logic cmd, logic [10:0] size,
			logic [15:0] addr);
		pool_result_t r;
		int unsigned  idx;
		r.status = ST_DONE;
		r.addr = '0;
		if (cmd == CMD_ALLOC) begin
			if (size == SMALL_SIZE && small_left != 0) begin
				r.status = ST_NO_BLOCK;
				for (int i = 0; i < SMALL_BLOCKS; i++) begin
					if (!small_map[i]) begin
						small_map[i] = 1'b1;
						small_left--;
						r.status = ST_DONE;
						r.addr = 16'(i * 32);
						break;
					end
				end
			end else if (size == SMALL_SIZE || size == LARGE_SIZE) begin
				if (large_left != 0) r = grant_large();
				else r.status = ST_NO_BLOCK;
			end else begin
				r.status = ST_BAD_SIZE;
			end
		end else if (addr < LARGE_BASE) begin
			idx = addr / 32;
			if (idx < SMALL_BLOCKS) begin
				small_map[idx] = 1'b0;
				if (small_left < small_total()) small_left++;
			end
		end else begin
			idx = (addr - LARGE_BASE) / 1024;
			if (idx < LARGE_BLOCKS) begin
				large_map[idx] = 1'b0;
				if (large_left < large_total()) large_left++;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic send_request(input logic cmd, input logic [10:0] size,
			input logic [15:0] addr, output pool_result_t r);
		r = predict_result(cmd, size, addr);
		expected_results.push_back(r);
		while (!steady && $urandom_range(99) < 16) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, addr, size, cmd};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [10:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SMALL_COUNT) small_count_reg = value;
		else large_count_reg = value[5:0];
		reload_pools();
	endtask

	// receive results, stall at random or for a requested stretch
	always @(posedge clk) begin
		pool_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata[1:0] != want.status)
					report_mismatch($sformatf("status got %0d expected %0d",
						m_axis_tdata[1:0], want.status));
				if (m_axis_tdata[17:2] != want.addr)
					report_mismatch($sformatf("granted_address got %h expected %h",
						m_axis_tdata[17:2], want.addr));
			end
		end
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || ($urandom_range(99) >= 16);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("two_class_pool_allocator_tb failed");
			$finish;
		end
	end

	task automatic test_reset_state();
		pool_result_t r;
		send_request(CMD_ALLOC, SMALL_SIZE, 16'h0000, r);
		send_request(CMD_ALLOC, LARGE_SIZE, 16'h0000, r);
		send_request(CMD_ALLOC, 11'd0, 16'hffff, r);
		send_request(CMD_ALLOC, 11'h7ff, 16'h0000, r);
		send_request(CMD_FREE, 11'h7ff, 16'h0000, r);
		send_request(CMD_FREE, 11'd0, 16'hffff, r);
		send_request(CMD_ALLOC, SMALL_SIZE, 16'h0000, r);
	endtask

	// register values above capacity saturate; odd sizes and unaligned frees
	task automatic test_extremes();
		pool_result_t r;
		write_register(REG_SMALL_COUNT, 11'h7ff);
		write_register(REG_LARGE_COUNT, 11'h7ff);
		send_request(CMD_ALLOC, SMALL_SIZE, 16'h0000, r);
		send_request(CMD_ALLOC, LARGE_SIZE, 16'h0000, r);
		send_request(CMD_ALLOC, 11'd31, 16'h0000, r);
		send_request(CMD_ALLOC, 11'd33, 16'h0000, r);
		send_request(CMD_ALLOC, 11'd1056, 16'h0000, r);
		send_request(CMD_FREE, 11'd0, 16'h7fff, r);
		send_request(CMD_FREE, 11'd0, 16'h001f, r);
		send_request(CMD_ALLOC, SMALL_SIZE, 16'h0000, r);
		send_request(CMD_FREE, 11'd0, LARGE_BASE + 16'd5, r);
		send_request(CMD_FREE, 11'd0, 16'hffff, r);
		send_request(CMD_ALLOC, LARGE_SIZE, 16'h0000, r);
	endtask

	// small requests spill into the large pool once the small pool is used up
	task automatic test_fallback();
		pool_result_t r;
		write_register(REG_SMALL_COUNT, 11'd1);
		write_register(REG_LARGE_COUNT, 11'd2);
		repeat (4) send_request(CMD_ALLOC, SMALL_SIZE, 16'h0000, r);
		send_request(CMD_ALLOC, LARGE_SIZE, 16'h0000, r);
		send_request(CMD_FREE, 11'd0, LARGE_BASE, r);
		send_request(CMD_ALLOC, LARGE_SIZE, 16'h0000, r);
		write_register(REG_LARGE_COUNT, 11'd64);
		repeat (2) send_request(CMD_ALLOC, SMALL_SIZE, 16'h0000, r);
		send_request(CMD_ALLOC, LARGE_SIZE, 16'h0000, r);
	endtask

	// counter nonzero with the large map full: no grant, no fallback
	task automatic test_full_map();
		pool_result_t r;
		write_register(REG_SMALL_COUNT, 11'd0);
		write_register(REG_LARGE_COUNT, 11'd32);
		steady = 1'b1;
		repeat (LARGE_BLOCKS) send_request(CMD_ALLOC, LARGE_SIZE, 16'h0000, r);
		repeat (2) send_request(CMD_FREE, 11'd0, LARGE_BASE, r);
		repeat (2) send_request(CMD_ALLOC, LARGE_SIZE, 16'h0000, r);
		send_request(CMD_ALLOC, SMALL_SIZE, 16'h0000, r);
		drain();
		steady = 1'b0;
	endtask

	// hold the result side while requests keep coming
	task automatic test_backpressure();
		pool_result_t r;
		write_register(REG_SMALL_COUNT, 11'd4);
		write_register(REG_LARGE_COUNT, 11'd2);
		hold_request = 300;
		repeat (40) begin
			if ($urandom_range(1))
				send_request(CMD_ALLOC, $urandom_range(1) ? SMALL_SIZE : LARGE_SIZE,
					16'h0000, r);
			else
				send_request(CMD_FREE, 11'($urandom),
					$urandom_range(1) ? 16'($urandom_range(127)) : LARGE_BASE, r);
		end
	endtask

	task automatic test_random_traffic(input logic [10:0] small_cnt,
			input logic [10:0] large_cnt, input int items);
		pool_result_t r;
		logic [15:0]  live[$];
		logic [15:0]  a;
		logic         cmd;
		int unsigned  roll;
		int           pick;
		write_register(REG_SMALL_COUNT, small_cnt);
		write_register(REG_LARGE_COUNT, large_cnt);
		repeat (items) begin
			roll = $urandom_range(99);
			if (roll < 45) begin
				cmd = CMD_ALLOC;
				send_request(cmd, ($urandom_range(2) == 0) ? LARGE_SIZE : SMALL_SIZE,
					16'($urandom), r);
			end else if (roll < 80 && live.size() != 0) begin
				cmd = CMD_FREE;
				pick = $urandom_range(live.size() - 1);
				a = live[pick];
				live.delete(pick);
				a = a + ((a < LARGE_BASE) ? 16'($urandom_range(31))
					: 16'($urandom_range(1023)));
				send_request(cmd, 11'($urandom), a, r);
			end else if (roll < 90) begin
				cmd = CMD_FREE;
				send_request(cmd, 11'($urandom), 16'($urandom), r);
			end else begin
				cmd = CMD_ALLOC;
				send_request(cmd, 11'($urandom), 16'($urandom), r);
			end
			if (cmd == CMD_ALLOC && r.status == ST_DONE) live.push_back(r.addr);
		end
	endtask

	initial begin
		small_count_reg = '0;
		large_count_reg = '0;
		reload_pools();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_extremes();
		test_fallback();
		test_full_map();
		test_backpressure();
		test_random_traffic(11'd1024, 11'd32, 90);
		test_random_traffic(11'd3, 11'd2, 90);
		test_random_traffic(11'd0, 11'd5, 90);
		test_random_traffic(11'd16, 11'd0, 90);
		test_random_traffic(11'($urandom_range(40)), 11'($urandom_range(63)), 90);
		drain();
		if (mismatches == 0) begin
			$display("two_class_pool_allocator_tb passed");
		end else begin
			$display("two_class_pool_allocator_tb failed");
		end
		$finish;
	end

endmodule
